// ===== rtl/smin_pkg.sv =====
// Shared constants and codes for the stack with remove-minimum.
`timescale 1ns / 1ps
`default_nettype none

package smin_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = 5;
   localparam int WORD_W      = 32;

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STACK_DEPTH);

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [WORD_W-1:0]  word_type;

endpackage

`default_nettype wire

// ===== rtl/smin_ram.sv =====
// Entry store: one write port and one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module smin_ram (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire smin_pkg::idx_type  wr_addr,
   input  wire smin_pkg::word_type wr_data,
   input  wire smin_pkg::idx_type  rd_addr,
   output smin_pkg::word_type      rd_data
);
   import smin_pkg::*;

   word_type mem_ff [STACK_DEPTH];
   word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/stack_with_remove_minimum_core.sv =====
// Top level: request sequencer and shared compare unit around the entry store.
// Push, an empty pop or remove, and an unused action give their result in the cycle after start.
// Pop reads the top word from the store and gives it as its result from state POP_WAIT.
// Remove scans from the top down through one comparator, then moves each entry above the
// minimum down one place to close the gap; its result follows the last move, or the scan if
// the minimum was on top. Busy falls as the result word appears, so the next word may start
// in that cycle; the receiver cannot stall. A synchronous reset empties the stack.
`timescale 1ns / 1ps
`default_nettype none

module stack_with_remove_minimum_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_push_value,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_result_value,
   output logic [1:0]              rsp_status,
   output logic [4:0]              rsp_entry_count,
   output logic                    rsp_is_empty
);
   import smin_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      POP_WAIT,
      SCAN,
      SHIFT
   } state_type;

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   idx_type   idx_ff, idx_in;
   idx_type   best_idx_ff, best_idx_in;
   word_type  best_val_ff, best_val_in;
   logic      first_ff, first_in;
   logic      strobe_ff, strobe_in;
   word_type  value_ff, value_in;
   logic [1:0] status_ff, status_in;
   logic [4:0] count_seen_ff;

   logic     wr_en;
   idx_type  wr_addr;
   word_type wr_data;
   idx_type  rd_addr;
   word_type rd_data;
   idx_type  top_idx;
   logic     take_new;

   smin_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign top_idx  = count_ff[IDX_W-1:0] - 1'b1;
   assign take_new = first_ff || ($signed(rd_data) < $signed(best_val_ff));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      first_in    = first_ff;
      strobe_in   = 1'b0;
      value_in    = '0;
      status_in   = STATUS_OK;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = word_type'(req_push_value);
      rd_addr     = top_idx;
      case (state_ff)
         IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_PUSH: begin
                     strobe_in = 1'b1;
                     if (count_ff == COUNT_FULL) begin
                        status_in = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STATUS_EMPTY;
                     end else begin
                        state_in = POP_WAIT;
                     end
                  end
                  ACT_REMOVE: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STATUS_EMPTY;
                     end else begin
                        idx_in   = top_idx;
                        first_in = 1'b1;
                        state_in = SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         POP_WAIT: begin
            strobe_in = 1'b1;
            value_in  = rd_data;
            count_in  = count_ff - 1'b1;
            state_in  = IDLE;
         end
         SCAN: begin
            first_in = 1'b0;
            if (take_new) begin
               best_val_in = rd_data;
               best_idx_in = idx_ff;
            end
            if (idx_ff == '0) begin
               if (best_idx_in == top_idx) begin
                  strobe_in = 1'b1;
                  value_in  = best_val_in;
                  count_in  = count_ff - 1'b1;
                  state_in  = IDLE;
               end else begin
                  rd_addr  = best_idx_in + 1'b1;
                  idx_in   = best_idx_in;
                  state_in = SHIFT;
               end
            end else begin
               idx_in  = idx_ff - 1'b1;
               rd_addr = idx_ff - 1'b1;
            end
         end
         SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            if ((idx_ff + 1'b1) == top_idx) begin
               strobe_in = 1'b1;
               value_in  = best_val_ff;
               count_in  = count_ff - 1'b1;
               state_in  = IDLE;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_addr = idx_ff + 2'd2;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         count_ff  <= '0;
         first_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         strobe_ff <= strobe_in;
      end
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      count_seen_ff <= 5'(count_in);
   end

   assign busy             = (state_ff != IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_result_value = $signed(value_ff);
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = count_seen_ff;
   assign rsp_is_empty     = (count_seen_ff == 5'd0);

endmodule

`default_nettype wire

// ===== rtl/smin_checker.sv =====
// Port-level checks for the stack with remove-minimum, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module smin_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [1:0]         req_action,
   input wire logic signed [31:0] req_push_value,
   input wire logic               rsp_strobe,
   input wire logic signed [31:0] rsp_result_value,
   input wire logic [1:0]         rsp_status,
   input wire logic [4:0]         rsp_entry_count,
   input wire logic               rsp_is_empty
);
   import smin_pkg::*;

   a_push_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action == ACT_PUSH) |=> (rsp_strobe && !busy))
      else $error("push word did not answer in one cycle");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_is_empty == (rsp_entry_count == 5'd0)))
      else $error("empty flag disagrees with entry count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_FULL) |-> (rsp_entry_count == 5'(STACK_DEPTH)))
      else $error("full status without a full stack");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_OK) |-> (rsp_result_value == 32'sd0))
      else $error("error word carries a non-zero value");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result word while still busy");

endmodule

bind stack_with_remove_minimum_core smin_checker u_smin_checker (.*);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the stack with remove-minimum: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
   import smin_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam word_type   WORD_MAX   = 32'h7fff_ffff;
   localparam word_type   WORD_MIN   = 32'h8000_0000;
   localparam int         RANDOM_WORDS = 2000;

   typedef struct packed {
      word_type   value;
      logic [1:0] status;
      count_type  count;
      logic       empty;
   } stack_result_type;

   typedef struct {
      logic [1:0]       action;
      word_type         value;
      int               reps;
      bit               typed;
      stack_result_type want;
   } stim_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_action;
   logic signed [31:0] req_push_value;
   logic               rsp_strobe;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_entry_count;
   logic               rsp_is_empty;

   word_type         model_mem [STACK_DEPTH];
   int               model_fill;
   stack_result_type pending_results [$];
   stim_row_type     plan [$];
   int               fail_count;

   stack_with_remove_minimum_core u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_push_value   (req_push_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic stack_result_type apply_stack_op(logic [1:0] act, word_type val);
      stack_result_type r;
      int               best;
      r        = '0;
      r.status = STATUS_OK;
      case (act)
         ACT_PUSH: begin
            if (model_fill >= STACK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               model_mem[model_fill] = val;
               model_fill++;
            end
         end
         ACT_POP: begin
            if (model_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               model_fill--;
               r.value = model_mem[model_fill];
            end
         end
         ACT_REMOVE: begin
            if (model_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               best = model_fill - 1;
               for (int i = model_fill - 2; i >= 0; i--) begin
                  if ($signed(model_mem[i]) < $signed(model_mem[best])) best = i;
               end
               r.value = model_mem[best];
               for (int i = best; i < model_fill - 1; i++) model_mem[i] = model_mem[i + 1];
               model_fill--;
            end
         end
         default: ;
      endcase
      r.count = count_type'(model_fill);
      r.empty = (model_fill == 0);
      return r;
   endfunction

   task automatic send_word(logic [1:0] act, word_type val, bit typed, stack_result_type want);
      stack_result_type predicted;
      start          <= 1'b1;
      req_action     <= act;
      req_push_value <= val;
      do @(posedge clock); while (busy);
      predicted = apply_stack_op(act, val);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic idle_for(int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic word_type pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return word_type'($urandom);
      if (sel < 8) return word_type'($urandom_range(0, 8) - 4);
      case ($urandom_range(0, 3))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [1:0] pick_action(bit growing);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return ACT_UNUSED;
      if (growing) begin
         if (sel < 70) return ACT_PUSH;
         if (sel < 82) return ACT_POP;
         return ACT_REMOVE;
      end
      if (sel < 25) return ACT_PUSH;
      if (sel < 55) return ACT_POP;
      return ACT_REMOVE;
   endfunction

   always @(posedge clock) begin
      stack_result_type got;
      stack_result_type want;
      if (!reset && rsp_strobe) begin
         got = '{rsp_result_value, rsp_status, rsp_entry_count, rsp_is_empty};
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected word: value %0d status %0d count %0d empty %0b",
                        $realtime, $signed(got.value), got.status, got.count, got.empty);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: mismatch: expected value %0d status %0d count %0d empty %0b,",
                           $realtime, $signed(want.value), want.status, want.count,
                           want.empty);
                  $display("   got value %0d status %0d count %0d empty %0b",
                           $signed(got.value), got.status, got.count, got.empty);
               end
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int  sent;
      int  burst;
      int  phase_left;
      bit  growing;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_action     <= ACT_PUSH;
      req_push_value <= '0;
      fail_count     = 0;
      model_fill     = 0;
      foreach (model_mem[i]) model_mem[i] = '0;

      plan.push_back('{ACT_POP,    '0,       1, 1, '{'0, STATUS_EMPTY, 5'd0, 1'b1}});
      plan.push_back('{ACT_REMOVE, '0,       1, 1, '{'0, STATUS_EMPTY, 5'd0, 1'b1}});
      plan.push_back('{ACT_UNUSED, '1,       1, 1, '{'0, STATUS_OK,    5'd0, 1'b1}});
      plan.push_back('{ACT_PUSH,   WORD_MAX, 1, 1, '{'0, STATUS_OK,    5'd1, 1'b0}});
      plan.push_back('{ACT_PUSH,   WORD_MIN, 1, 1, '{'0, STATUS_OK,    5'd2, 1'b0}});
      plan.push_back('{ACT_POP,    '0,       1, 1, '{WORD_MIN, STATUS_OK, 5'd1, 1'b0}});
      plan.push_back('{ACT_POP,    '1,       1, 1, '{WORD_MAX, STATUS_OK, 5'd0, 1'b1}});
      plan.push_back('{ACT_PUSH,   32'd5,    1, 0, '0});
      plan.push_back('{ACT_PUSH,   32'd3,    1, 0, '0});
      plan.push_back('{ACT_PUSH,   32'd7,    1, 0, '0});
      plan.push_back('{ACT_PUSH,   32'd3,    1, 0, '0});
      plan.push_back('{ACT_REMOVE, '0,       1, 0, '0});
      plan.push_back('{ACT_POP,    '0,       1, 0, '0});
      plan.push_back('{ACT_PUSH,   '1,       14, 0, '0});
      plan.push_back('{ACT_PUSH,   32'h1234, 1, 1, '{'0, STATUS_FULL, COUNT_FULL, 1'b0}});
      plan.push_back('{ACT_UNUSED, '0,       1, 1, '{'0, STATUS_OK,   COUNT_FULL, 1'b0}});
      plan.push_back('{ACT_REMOVE, '0,       1, 0, '0});
      plan.push_back('{ACT_PUSH,   WORD_MIN, 1, 0, '0});
      plan.push_back('{ACT_REMOVE, '0,       1, 0, '0});
      plan.push_back('{ACT_REMOVE, '0,       15, 0, '0});
      plan.push_back('{ACT_POP,    '0,       1, 1, '{'0, STATUS_EMPTY, 5'd0, 1'b1}});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         for (int k = 0; k < plan[r].reps; k++) begin
            send_word(plan[r].action, plan[r].value, plan[r].typed, plan[r].want);
            if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 20));
         end
      end
      wait_drained();

      sent       = 0;
      growing    = 1'b1;
      phase_left = $urandom_range(20, 80);
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
            send_word(pick_action(growing), pick_value(), 1'b0, '0);
            sent++;
            phase_left--;
            if (phase_left == 0) begin
               growing    = !growing;
               phase_left = $urandom_range(20, 80);
            end
            if (sent % 400 == 0) wait_drained();
         end
         if ((sent / 150) % 3 != 0) idle_for($urandom_range(0, 24));
      end

      wait_drained();
      repeat (48) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
